// ===== hw/rtl/packed_yuv_to_planar_i420_macros.svh =====
// Assertion macros for the file that carries concurrent checks.
`ifndef PACKED_YUV_TO_PLANAR_I420_MACROS_SVH
`define PACKED_YUV_TO_PLANAR_I420_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PYI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PYI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pyi_pkg.sv =====
package pyi_pkg;

    localparam int OFFSET_W = 25;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 13;

    localparam logic [1:0] MODE_YUYV = 2'd0;
    localparam logic [1:0] MODE_UYVY = 2'd1;
    localparam logic [1:0] MODE_NV12 = 2'd2;

    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [1:0]       RESET_MODE   = MODE_YUYV;
    localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

    // Cycles from a register write until the derived frame geometry is final.
    localparam logic [2:0] SETTLE_CYCLES = 3'd4;

endpackage

// ===== hw/rtl/pyi_cfg.sv =====
module pyi_cfg
    import pyi_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int EW = $clog2(MAX_WIDTH + 1),
    localparam int EH = $clog2(MAX_HEIGHT + 1),
    localparam int YW = EW + EH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output logic [1:0]          source_mode,
    output logic                busy,
    output logic [EH-1:0]       row_last,
    output logic [EW:0]         byte_last,
    output logic [YW-1:0]       luma_size,
    output logic [YW:0]         total_last,
    output logic [OFFSET_W-1:0] u_start,
    output logic [OFFSET_W-1:0] v_start
);

    logic [1:0]          mode_reg;
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    logic [2:0]          settle_reg;
    logic [EW-1:0]       eff_w_reg;
    logic [EH-1:0]       eff_h_reg;
    logic [EW-1:0]       eff_w_next;
    logic [EH-1:0]       eff_h_next;
    logic [YW-1:0]       ysize_reg;
    logic [EH-1:0]       row_last_reg;
    logic [EW:0]         byte_last_reg;
    logic [YW:0]         total_last_reg;
    logic [OFFSET_W-1:0] u_start_reg;
    logic [OFFSET_W-1:0] v_start_reg;
    logic [YW:0]         v_sum;
    logic [CFG_W:0]      w_wide;
    logic [CFG_W:0]      h_wide;
    logic [1:0]          index;
    logic                wr;
    logic                wr_known;

    assign index    = paddr[3:2];
    assign wr       = psel && penable && pwrite;
    assign wr_known = wr && (index == REG_MODE || index == REG_WIDTH || index == REG_HEIGHT);
    assign pready   = 1'b1;

    always_comb
    begin
        unique case (index)
            REG_MODE:   prdata = {{(DATA_W - 2){1'b0}}, mode_reg};
            REG_WIDTH:  prdata = {{(DATA_W - CFG_W){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(DATA_W - CFG_W){1'b0}}, height_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= RESET_MODE;
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            settle_reg <= SETTLE_CYCLES;
        end
        else
        begin
            if (wr)
            begin
                unique case (index)
                    REG_MODE:   mode_reg   <= pwdata[1:0];
                    REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                    REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                    default:    ;
                endcase
            end
            if (wr_known)
                settle_reg <= SETTLE_CYCLES;
            else if (settle_reg != 3'd0)
                settle_reg <= settle_reg - 3'd1;
        end
    end

    // Sizes are held within range and rounded down to an even count.
    always_comb
    begin
        w_wide = {1'b0, width_reg};
        h_wide = {1'b0, height_reg};
        if (w_wide < (CFG_W + 1)'(2))
            w_wide = (CFG_W + 1)'(2);
        if (w_wide > (CFG_W + 1)'(MAX_WIDTH))
            w_wide = (CFG_W + 1)'(MAX_WIDTH);
        if (h_wide < (CFG_W + 1)'(2))
            h_wide = (CFG_W + 1)'(2);
        if (h_wide > (CFG_W + 1)'(MAX_HEIGHT))
            h_wide = (CFG_W + 1)'(MAX_HEIGHT);
        w_wide[0] = 1'b0;
        h_wide[0] = 1'b0;
        eff_w_next = EW'(w_wide);
        eff_h_next = EH'(h_wide);
        v_sum      = {1'b0, ysize_reg} + {3'b000, ysize_reg[YW-1:2]};
    end

    always_ff @(posedge clk)
    begin
        eff_w_reg      <= eff_w_next;
        eff_h_reg      <= eff_h_next;
        ysize_reg      <= {{EH{1'b0}}, eff_w_reg} * {{EW{1'b0}}, eff_h_reg};
        row_last_reg   <= eff_h_reg - EH'(1);
        byte_last_reg  <= {eff_w_reg, 1'b0} - (EW + 1)'(1);
        total_last_reg <= {1'b0, ysize_reg} + {2'b00, ysize_reg[YW-1:1]} - (YW + 1)'(1);
        u_start_reg    <= OFFSET_W'(ysize_reg);
        v_start_reg    <= OFFSET_W'(v_sum);
    end

    assign source_mode = mode_reg;
    assign busy        = (settle_reg != 3'd0);
    assign row_last    = row_last_reg;
    assign byte_last   = byte_last_reg;
    assign luma_size   = ysize_reg;
    assign total_last  = total_last_reg;
    assign u_start     = u_start_reg;
    assign v_start     = v_start_reg;

endmodule

// ===== hw/rtl/pyi_router.sv =====
module pyi_router
    import pyi_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int EW = $clog2(MAX_WIDTH + 1),
    localparam int EH = $clog2(MAX_HEIGHT + 1),
    localparam int YW = EW + EH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  logic                step,
    input  logic                advance,
    input  logic                item_valid,
    input  logic [7:0]          item_byte,
    input  logic [1:0]          source_mode,
    input  logic [EH-1:0]       row_last,
    input  logic [EW:0]         byte_last,
    input  logic [YW-1:0]       luma_size,
    input  logic [YW:0]         total_last,
    input  logic [OFFSET_W-1:0] u_start,
    input  logic [OFFSET_W-1:0] v_start,
    output logic                out_valid,
    output logic                write_enable,
    output logic [1:0]          plane_select,
    output logic [OFFSET_W-1:0] dest_offset,
    output logic [7:0]          byte_value,
    output logic                frame_last
);

    logic [EH-1:0]       row_reg;
    logic [EW:0]         col_reg;
    logic [OFFSET_W-1:0] luma_ptr_reg;
    logic [OFFSET_W-1:0] u_ptr_reg;
    logic [OFFSET_W-1:0] v_ptr_reg;
    logic [YW:0]         nv_cnt_reg;
    logic                out_valid_reg;
    logic                we_reg;
    logic [1:0]          plane_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [7:0]          value_reg;
    logic                last_reg;

    logic                we_next;
    logic [1:0]          plane_next;
    logic [OFFSET_W-1:0] offset_next;
    logic                last_next;
    logic                is_luma;
    logic                row_end;

    always_comb
    begin
        we_next     = 1'b0;
        plane_next  = PLANE_Y;
        offset_next = '0;
        is_luma     = 1'b0;
        row_end     = (col_reg >= byte_last);
        if (source_mode[1])
        begin
            we_next = 1'b1;
            if (nv_cnt_reg < {1'b0, luma_size})
            begin
                plane_next  = PLANE_Y;
                offset_next = luma_ptr_reg;
            end
            else if (nv_cnt_reg[0] == luma_size[0])
            begin
                plane_next  = PLANE_U;
                offset_next = u_ptr_reg;
            end
            else
            begin
                plane_next  = PLANE_V;
                offset_next = v_ptr_reg;
            end
            last_next = (nv_cnt_reg >= total_last);
        end
        else
        begin
            is_luma = (source_mode == MODE_YUYV) ? !col_reg[0] : col_reg[0];
            if (is_luma)
            begin
                we_next     = 1'b1;
                plane_next  = PLANE_Y;
                offset_next = luma_ptr_reg;
            end
            else if (!row_reg[0])
            begin
                we_next = 1'b1;
                if (!col_reg[1])
                begin
                    plane_next  = PLANE_U;
                    offset_next = u_ptr_reg;
                end
                else
                begin
                    plane_next  = PLANE_V;
                    offset_next = v_ptr_reg;
                end
            end
            last_next = (row_reg >= row_last) && row_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            luma_ptr_reg  <= '0;
            u_ptr_reg     <= '0;
            v_ptr_reg     <= '0;
            nv_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= item_valid;
            if (restart || (step && last_next))
            begin
                row_reg      <= '0;
                col_reg      <= '0;
                luma_ptr_reg <= '0;
                u_ptr_reg    <= u_start;
                v_ptr_reg    <= v_start;
                nv_cnt_reg   <= '0;
            end
            else if (step)
            begin
                if (we_next && plane_next == PLANE_Y)
                    luma_ptr_reg <= luma_ptr_reg + OFFSET_W'(1);
                if (we_next && plane_next == PLANE_U)
                    u_ptr_reg <= u_ptr_reg + OFFSET_W'(1);
                if (we_next && plane_next == PLANE_V)
                    v_ptr_reg <= v_ptr_reg + OFFSET_W'(1);
                if (source_mode[1])
                    nv_cnt_reg <= nv_cnt_reg + (YW + 1)'(1);
                else if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + EH'(1);
                end
                else
                    col_reg <= col_reg + (EW + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            we_reg     <= we_next;
            plane_reg  <= plane_next;
            offset_reg <= offset_next;
            value_reg  <= we_next ? item_byte : 8'd0;
            last_reg   <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = we_reg;
    assign plane_select = plane_reg;
    assign dest_offset  = offset_reg;
    assign byte_value   = value_reg;
    assign frame_last   = last_reg;

endmodule

// ===== hw/rtl/packed_yuv_to_planar_i420.sv =====
// Routes a YUYV, UYVY or NV12 source frame, one byte per item, into writes
// for a planar I420 buffer.
// The input channel (in_valid, in_ready, source_byte) takes source bytes in
// raster order. The output channel (out_valid, out_ready and the result
// fields) gives one item per source byte: plane, byte offset, value and a
// write enable that is low for chroma bytes dropped on odd packed rows.
// frame_last marks the result for the final byte of each frame.
// An accepted item is held in the input register, and its result is
// registered in the result register whenever the output can advance.
// One item is taken every cycle while the receiver keeps taking results
// and no rebuild runs; counters and pointers in the router step per byte.
// When the receiver stalls, the result register holds and the input
// register fills, after which in_ready falls until the receiver takes.
// After reset, and after every write to a known register, the frame
// geometry is rebuilt with in_ready low, and the frame restarts from its
// first byte. Reset gives YUYV at 640 by 480.
`include "packed_yuv_to_planar_i420_macros.svh"

module packed_yuv_to_planar_i420
    import pyi_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          source_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                write_enable,
    output logic [1:0]          plane_select,
    output logic [OFFSET_W-1:0] dest_offset,
    output logic [7:0]          byte_value,
    output logic                frame_last
);

    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int EH = $clog2(MAX_HEIGHT + 1);
    localparam int YW = EW + EH;

    logic                cfg_busy;
    logic [1:0]          mode;
    logic [EH-1:0]       row_last;
    logic [EW:0]         byte_last;
    logic [YW-1:0]       luma_size;
    logic [YW:0]         total_last;
    logic [OFFSET_W-1:0] u_start;
    logic [OFFSET_W-1:0] v_start;
    logic                hold_valid_reg;
    logic [7:0]          hold_byte_reg;
    logic                advance;
    logic                step;

    pyi_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .source_mode (mode),
        .busy        (cfg_busy),
        .row_last    (row_last),
        .byte_last   (byte_last),
        .luma_size   (luma_size),
        .total_last  (total_last),
        .u_start     (u_start),
        .v_start     (v_start)
    );

    assign advance  = !out_valid || out_ready;
    assign step     = hold_valid_reg && advance;
    assign in_ready = !cfg_busy && (!hold_valid_reg || advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (in_ready)
            hold_valid_reg <= in_valid;
        else if (advance)
            hold_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            hold_byte_reg <= source_byte;
    end

    pyi_router #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_router (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (cfg_busy),
        .step         (step),
        .advance      (advance),
        .item_valid   (hold_valid_reg),
        .item_byte    (hold_byte_reg),
        .source_mode  (mode),
        .row_last     (row_last),
        .byte_last    (byte_last),
        .luma_size    (luma_size),
        .total_last   (total_last),
        .u_start      (u_start),
        .v_start      (v_start),
        .out_valid    (out_valid),
        .write_enable (write_enable),
        .plane_select (plane_select),
        .dest_offset  (dest_offset),
        .byte_value   (byte_value),
        .frame_last   (frame_last)
    );

    `PYI_ASSERT_NOW(a_drop_is_blank, out_valid && !write_enable,
        plane_select == PLANE_Y && dest_offset == '0 && byte_value == 8'd0,
        "dropped item carries a non-zero payload")
    `PYI_ASSERT_NEXT(a_cfg_blocks_input,
        psel && penable && pwrite && (paddr[3:2] == REG_MODE || paddr[3:2] == REG_WIDTH),
        !in_ready, "input taken straight after a register write")
    `PYI_ASSERT_NOW(a_plane_code, out_valid, plane_select != 2'd3,
        "result names a plane that does not exist")

endmodule

// ===== bench/packed_yuv_to_planar_i420_test.sv =====
module packed_yuv_to_planar_i420_test;
    import pyi_pkg::*;

    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int CHROMA_QUARTER = 4;
    localparam int REG_COUNT      = 3;
    localparam int RANDOM_ITEMS   = 400;
    localparam int IDLE_LIMIT     = 2000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [ADDR_W-1:0] ADDR_MODE   = ADDR_W'(4 * REG_MODE);
    localparam logic [ADDR_W-1:0] ADDR_WIDTH  = ADDR_W'(4 * REG_WIDTH);
    localparam logic [ADDR_W-1:0] ADDR_HEIGHT = ADDR_W'(4 * REG_HEIGHT);
    localparam logic [ADDR_W-1:0] ADDR_SPARE  = ADDR_W'(4 * REG_COUNT);

    typedef struct packed
    {
        logic                we;
        logic [1:0]          plane;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          value;
        logic                last;
    } dest_write_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct
    {
        row_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [7:0]        src;
        bit                typed;
        dest_write_t       wr;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          source_byte;
    logic                out_valid;
    logic                out_ready;
    logic                write_enable;
    logic [1:0]          plane_select;
    logic [OFFSET_W-1:0] dest_offset;
    logic [7:0]          byte_value;
    logic                frame_last;

    packed_yuv_to_planar_i420
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_byte  (source_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_enable (write_enable),
        .plane_select (plane_select),
        .dest_offset  (dest_offset),
        .byte_value   (byte_value),
        .frame_last   (frame_last)
    );

    logic [1:0]       cur_mode;
    logic [CFG_W-1:0] cur_width;
    logic [CFG_W-1:0] cur_height;
    int unsigned      row_idx;
    int unsigned      col_idx;
    int unsigned      y_next;
    int unsigned      u_next;
    int unsigned      v_next;
    int unsigned      nv_seen;

    dest_write_t routed_writes[$];
    stim_row_t   directed_rows[$];

    bit calm;
    int mismatches;
    int items_sent;
    int results_seen;
    int frames_done;
    int reg_writes;
    int idle_cycles;
    int stall_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] raw, input int unsigned maxv);
        int unsigned v;
        v = raw;
        if (v < 2) v = 2;
        if (v > maxv) v = maxv;
        return v & ~32'd1;
    endfunction

    function automatic int unsigned luma_size();
        return eff_dim(cur_width, MAX_WIDTH) * eff_dim(cur_height, MAX_HEIGHT);
    endfunction

    function automatic void restart_frame_state();
        int unsigned ysize;
        ysize   = luma_size();
        row_idx = 0;
        col_idx = 0;
        y_next  = 0;
        nv_seen = 0;
        u_next  = ysize;
        v_next  = ysize + ysize / CHROMA_QUARTER;
    endfunction

    function automatic dest_write_t route_byte(input logic [7:0] b);
        dest_write_t r;
        int unsigned w;
        int unsigned h;
        int unsigned ysize;
        bit          is_luma;
        bit          row_end;
        r = '0;
        w = eff_dim(cur_width, MAX_WIDTH);
        h = eff_dim(cur_height, MAX_HEIGHT);
        if (cur_mode >= MODE_NV12)
        begin
            ysize   = w * h;
            r.we    = 1'b1;
            r.value = b;
            if (nv_seen < ysize)
            begin
                r.plane  = PLANE_Y;
                r.offset = y_next[OFFSET_W-1:0];
                y_next++;
            end
            else if (((nv_seen - ysize) & 1) == 0)
            begin
                r.plane  = PLANE_U;
                r.offset = u_next[OFFSET_W-1:0];
                u_next++;
            end
            else
            begin
                r.plane  = PLANE_V;
                r.offset = v_next[OFFSET_W-1:0];
                v_next++;
            end
            r.last = (nv_seen + 1 >= ysize + ysize / 2);
            if (r.last)
                restart_frame_state();
            else
                nv_seen++;
        end
        else
        begin
            is_luma = (cur_mode == MODE_YUYV) ? !col_idx[0] : col_idx[0];
            if (is_luma)
            begin
                r.we     = 1'b1;
                r.plane  = PLANE_Y;
                r.offset = y_next[OFFSET_W-1:0];
                r.value  = b;
                y_next++;
            end
            else if (!row_idx[0])
            begin
                r.we    = 1'b1;
                r.value = b;
                if (!col_idx[1])
                begin
                    r.plane  = PLANE_U;
                    r.offset = u_next[OFFSET_W-1:0];
                    u_next++;
                end
                else
                begin
                    r.plane  = PLANE_V;
                    r.offset = v_next[OFFSET_W-1:0];
                    v_next++;
                end
            end
            row_end = (col_idx + 1 >= 2 * w);
            r.last  = (row_idx + 1 >= h) && row_end;
            if (r.last)
                restart_frame_state();
            else if (row_end)
            begin
                col_idx = 0;
                row_idx++;
            end
            else
                col_idx++;
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    function automatic string show_write(input dest_write_t d);
        return $sformatf("we=%0d plane=%0d offset=%0d value=%02h last=%0d",
                         d.we, d.plane, d.offset, d.value, d.last);
    endfunction

    function automatic void add_item(input logic [7:0] b, input bit typed, input dest_write_t wr);
        stim_row_t row;
        row.kind  = ROW_ITEM;
        row.addr  = '0;
        row.data  = '0;
        row.src   = b;
        row.typed = typed;
        row.wr    = wr;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        stim_row_t row;
        row.kind  = ROW_WRITE;
        row.addr  = a;
        row.data  = d;
        row.src   = '0;
        row.typed = 1'b0;
        row.wr    = '0;
        directed_rows.push_back(row);
    endfunction

    // Every driving task starts and returns at a falling edge with nothing yet assigned there.
    task automatic push_byte(input logic [7:0] b, input bit typed, input dest_write_t wr);
        int          gap;
        dest_write_t predicted;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        source_byte <= b;
        do @(posedge clk); while (!in_ready);
        predicted = route_byte(b);
        routed_writes.push_back(typed ? wr : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic apb_access(input bit is_write, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d, output logic [DATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (routed_writes.size() != 0)
            @(negedge clk);
        repeat (int'(SETTLE_CYCLES) + 2) @(negedge clk);
    endtask

    task automatic configure(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] want;
        bit                known;
        known = 1'b1;
        apb_access(1'b1, a, d, rd);
        reg_writes++;
        case (a)
            ADDR_MODE:
            begin
                cur_mode = d[1:0];
                want     = DATA_W'(cur_mode);
            end
            ADDR_WIDTH:
            begin
                cur_width = d[CFG_W-1:0];
                want      = DATA_W'(cur_width);
            end
            ADDR_HEIGHT:
            begin
                cur_height = d[CFG_W-1:0];
                want       = DATA_W'(cur_height);
            end
            default:
            begin
                known = 1'b0;
                want  = '0;
            end
        endcase
        if (known)
        begin
            restart_frame_state();
            apb_access(1'b0, a, '0, rd);
            if (rd !== want)
                flag_error($sformatf("register at %0d reads %0h, expected %0h", a, rd, want));
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_dim_word();
        int          r;
        int unsigned raw;
        r = $urandom_range(0, 99);
        if (r < 75)
            raw = $urandom_range(1, 4) * 2;
        else if (r < 90)
            raw = $urandom_range(0, 17);
        else
            raw = $urandom_range(0, 8191);
        return ($urandom() & ~32'h1FFF) | raw;
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0 && gap_len() > 0)
        begin
            stall_left = gap_len();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        dest_write_t got;
        dest_write_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {write_enable, plane_select, dest_offset, byte_value, frame_last};
            results_seen++;
            if (frame_last)
                frames_done++;
            if (routed_writes.size() == 0)
                flag_error({"unexpected result: ", show_write(got)});
            else
            begin
                want = routed_writes.pop_front();
                if (got !== want)
                    flag_error({"result mismatch: expected ", show_write(want),
                                ", got ", show_write(got)});
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Stalled for %0d cycles with %0d results outstanding.",
                     idle_cycles, routed_writes.size());
            $display("FAIL packed_yuv_to_planar_i420");
            $finish;
        end
    end

    initial
    begin
        int          directed_items;
        int unsigned w;
        int unsigned h;
        int unsigned frame_bytes;
        int          n;
        int          pick;
        stim_row_t   row;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        source_byte = '0;
        out_ready   = 1'b0;
        calm        = 1'b0;
        stall_left  = 0;
        idle_cycles = 0;
        cur_mode    = RESET_MODE;
        cur_width   = RESET_WIDTH;
        cur_height  = RESET_HEIGHT;
        restart_frame_state();

        // Reset geometry, 640 by 480 YUYV.
        add_item(8'h00, 1'b1, '{1'b1, PLANE_Y, 25'd0, 8'h00, 1'b0});
        add_item(8'hFF, 1'b1, '{1'b1, PLANE_U, 25'd307200, 8'hFF, 1'b0});
        add_item(8'h5A, 1'b1, '{1'b1, PLANE_Y, 25'd1, 8'h5A, 1'b0});
        add_item(8'hA5, 1'b1, '{1'b1, PLANE_V, 25'd384000, 8'hA5, 1'b0});
        // Sizes below the minimum and odd sizes clamp to 2 by 2.
        add_write(ADDR_WIDTH, 32'd0);
        add_write(ADDR_HEIGHT, 32'd3);
        add_write(ADDR_MODE, DATA_W'(MODE_YUYV));
        add_item(8'h11, 1'b1, '{1'b1, PLANE_Y, 25'd0, 8'h11, 1'b0});
        add_item(8'h22, 1'b1, '{1'b1, PLANE_U, 25'd4, 8'h22, 1'b0});
        add_item(8'h33, 1'b1, '{1'b1, PLANE_Y, 25'd1, 8'h33, 1'b0});
        add_item(8'h44, 1'b1, '{1'b1, PLANE_V, 25'd5, 8'h44, 1'b0});
        add_item(8'h55, 1'b1, '{1'b1, PLANE_Y, 25'd2, 8'h55, 1'b0});
        add_item(8'h66, 1'b1, '{1'b0, PLANE_Y, 25'd0, 8'h00, 1'b0});
        add_item(8'h77, 1'b1, '{1'b1, PLANE_Y, 25'd3, 8'h77, 1'b0});
        add_item(8'h88, 1'b1, '{1'b0, PLANE_Y, 25'd0, 8'h00, 1'b1});
        add_write(ADDR_MODE, DATA_W'(MODE_UYVY));
        add_item(8'hC3, 1'b0, '0);
        add_item(8'h3C, 1'b0, '0);
        add_item(8'h96, 1'b0, '0);
        // The unused mode code behaves as NV12; a write past the register list changes nothing.
        add_write(ADDR_MODE, 32'hFFFF_FFFF);
        add_item(8'h01, 1'b1, '{1'b1, PLANE_Y, 25'd0, 8'h01, 1'b0});
        add_item(8'h80, 1'b1, '{1'b1, PLANE_Y, 25'd1, 8'h80, 1'b0});
        add_item(8'h7F, 1'b1, '{1'b1, PLANE_Y, 25'd2, 8'h7F, 1'b0});
        add_write(ADDR_SPARE, 32'hFFFF_FFFF);
        add_item(8'hFE, 1'b1, '{1'b1, PLANE_Y, 25'd3, 8'hFE, 1'b0});
        add_item(8'h10, 1'b1, '{1'b1, PLANE_U, 25'd4, 8'h10, 1'b0});
        add_item(8'hEF, 1'b1, '{1'b1, PLANE_V, 25'd5, 8'hEF, 1'b1});
        // Sizes above the maximum clamp to 4096 by 4096.
        add_write(ADDR_WIDTH, 32'hFFFF_FFFF);
        add_write(ADDR_HEIGHT, 32'h0000_1001);
        add_write(ADDR_MODE, DATA_W'(MODE_YUYV));
        add_item(8'h00, 1'b1, '{1'b1, PLANE_Y, 25'd0, 8'h00, 1'b0});
        add_item(8'hFF, 1'b1, '{1'b1, PLANE_U, 25'd16777216, 8'hFF, 1'b0});
        add_item(8'hAA, 1'b1, '{1'b1, PLANE_Y, 25'd1, 8'hAA, 1'b0});
        add_item(8'h55, 1'b1, '{1'b1, PLANE_V, 25'd20971520, 8'h55, 1'b0});

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                settle_pipeline();
                configure(row.addr, row.data);
            end
            else
                push_byte(row.src, row.typed, row.wr);
        end
        directed_items = items_sent;

        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            settle_pipeline();
            pick = $urandom_range(1, 7);
            if (pick[0])
                configure(ADDR_MODE, $urandom());
            if (pick[1])
                configure(ADDR_WIDTH, pick_dim_word());
            if (pick[2])
                configure(ADDR_HEIGHT, pick_dim_word());
            if ($urandom_range(0, 9) == 0)
                configure(ADDR_SPARE, $urandom());
            w = eff_dim(cur_width, MAX_WIDTH);
            h = eff_dim(cur_height, MAX_HEIGHT);
            frame_bytes = (cur_mode >= MODE_NV12) ? w * h * 3 / 2 : 2 * w * h;
            if (frame_bytes > 240)
                n = $urandom_range(4, 24);
            else if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, frame_bytes);
            else
                n = frame_bytes * $urandom_range(1, 2);
            repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end

        settle_pipeline();
        repeat (8) @(posedge clk);
        $display("Routed %0d source bytes (%0d directed) across %0d register writes.",
                 items_sent, directed_items, reg_writes);
        $display("Checked %0d destination writes, %0d complete frames, %0d mismatches.",
                 results_seen, frames_done, mismatches);
        if (mismatches == 0)
            $display("PASS packed_yuv_to_planar_i420");
        else
            $display("FAIL packed_yuv_to_planar_i420");
        $finish;
    end

endmodule
